// ----- hw/rtl/lztd_pkg.sv -----
// Shared types and constants for the LZ77 token decoder.
// No dependencies; imported by every module of the block but lztd_ram.
package lztd_pkg;

  // Fixed field widths
  localparam int unsigned OFF_W  = 13;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  // Parameter defaults
  localparam int unsigned HISTORY_DEPTH_DEF = 4096;
  localparam int unsigned MAX_MATCH_DEF     = 63;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_token;  // capture the accepted token
    logic rd_hist;     // read history at write pointer minus offset
    logic copy_emit;   // emit the read byte and append it to history
    logic lit_emit;    // emit the literal and append it to history
  } lztd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_copy;     // accepted token has a valid match to copy
    logic cnt_last;    // one copied byte remains
    logic out_free;    // output register can take a byte this cycle
  } lztd_sts_t;

endpackage

// ----- hw/rtl/lz77_token_decoder.sv -----
// Top level of the LZ77 token decoder: controller plus datapath.
// Depends on lztd_pkg, lztd_ctrl and lztd_datapath.
//
//  Channel  | Direction | tdata (low bit up)                         | tlast | tuser
//  s_axis   | in        | match_offset 13, match_length 6, literal 8 | -     | -
//  m_axis   | out       | out_byte 8                                 | last  | bad_token
//
// A token is first accepted; then each of its L copied bytes, with L its
// saturated match length, takes a history RAM read, then an emit and write back
// through the single write port; the literal is emitted last.
// Reset clears pointers, byte count, state and output valid; the history RAM
// is not cleared, since no entry is read before it is written.
// A stalled output holds the machine in its emit state; the next token is
// taken while the last byte of the previous one still waits downstream.
module lz77_token_decoder import lztd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_MATCH     = MAX_MATCH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // match_offset [12:0], match_length [18:13], literal_byte [26:19], zeros
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_byte [7:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // bad_token [0]
  output logic                   m_axis_tuser
);

  lztd_cmd_t cmd;
  lztd_sts_t sts;

  lztd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lztd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_MATCH     (MAX_MATCH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_offset_i  (s_axis_tdata[OFF_W-1:0]),
    .in_length_i  (s_axis_tdata[OFF_W+LEN_W-1:OFF_W]),
    .in_literal_i (s_axis_tdata[OFF_W+LEN_W+BYTE_W-1:OFF_W+LEN_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_bad_o    (m_axis_tuser)
  );

endmodule

// ----- hw/rtl/lztd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lztd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lztd_ctrl.sv -----
// Controller state machine of the LZ77 token decoder.
// Depends on lztd_pkg for the command and status structs.
module lztd_ctrl import lztd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lztd_sts_t sts_i,
  output lztd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_LIT
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_token = accept;
    case (state_q)
      S_IDLE:  ;
      S_READ:  cmd_o.rd_hist   = 1'b1;
      S_COPY:  cmd_o.copy_emit = sts_i.out_free;
      S_LIT:   cmd_o.lit_emit  = sts_i.out_free;
      default: ;
    endcase
  end

  // Advance state and the registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ready_q <= 1'b0;
            state_q <= sts_i.in_copy ? S_READ : S_LIT;
          end else begin
            ready_q <= 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_COPY;
        end
        S_COPY: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.cnt_last ? S_LIT : S_READ;
          end
        end
        S_LIT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/lztd_datapath.sv -----
// Datapath of the LZ77 token decoder: token registers, history pointers,
// history RAM and output register. Depends on lztd_pkg and lztd_ram.
module lztd_datapath import lztd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_MATCH     = MAX_MATCH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OFF_W-1:0]  in_offset_i,
  input  logic [LEN_W-1:0]  in_length_i,
  input  logic [BYTE_W-1:0] in_literal_i,
  input  lztd_cmd_t         cmd_i,
  output lztd_sts_t         sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  output logic              out_bad_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CW = (OFF_W > PW) ? OFF_W : PW;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_MATCH);
  localparam logic [PW:0]      DepthX = (PW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0]    LastAddr = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0]    DepthP = PW'(HISTORY_DEPTH);

  logic [AW-1:0]     wp_q;
  logic [PW-1:0]     produced_q;
  logic [PW-1:0]     off_q;
  logic [LEN_W-1:0]  cnt_q;
  logic [BYTE_W-1:0] lit_q;
  logic              bad_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_bad_q;

  logic [LEN_W-1:0]  len_sat;
  logic              in_bad;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic [PW:0]       wp_x;
  logic [PW:0]       rd_sum;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // Classify the incoming token
  assign len_sat = (in_length_i > MaxLen) ? MaxLen : in_length_i;
  assign in_bad  = (len_sat != '0) &&
                   ((in_offset_i == '0) || (CW'(in_offset_i) > CW'(produced_q)));

  assign sts_o.in_copy  = (len_sat != '0) && !in_bad;
  assign sts_o.cnt_last = (cnt_q == LEN_W'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Capture the token
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_token) begin
      off_q <= PW'(in_offset_i);
      lit_q <= in_literal_i;
      bad_q <= in_bad;
      cnt_q <= len_sat;
    end else if (cmd_i.copy_emit) begin
      cnt_q <= cnt_q - LEN_W'(1);
    end
  end

  // Read address: write pointer minus offset, wrapped into the window
  assign wp_x    = (PW+1)'(wp_q);
  assign rd_sum  = (wp_x >= (PW+1)'(off_q)) ? (wp_x - (PW+1)'(off_q))
                                            : (wp_x + DepthX - (PW+1)'(off_q));
  assign rd_addr = rd_sum[AW-1:0];

  assign emit      = cmd_i.copy_emit || cmd_i.lit_emit;
  assign emit_byte = cmd_i.copy_emit ? rd_data : lit_q;

  lztd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (emit),
    .waddr_i (wp_q),
    .wdata_i (emit_byte),
    .re_i    (cmd_i.rd_hist),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Advance write pointer and saturating byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      produced_q <= '0;
    end else if (emit) begin
      wp_q <= (wp_q == LastAddr) ? '0 : wp_q + AW'(1);
      if (produced_q != DepthP) begin
        produced_q <= produced_q + PW'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= cmd_i.lit_emit;
      out_bad_q  <= cmd_i.lit_emit && bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;

endmodule

// ----- verif/lztd_checker.sv -----
// Stream checker for the LZ77 token decoder: predicts every decoded byte.
// Depends on lztd_pkg; instantiated by tb beside the block.
`timescale 1ns / 100ps

module lztd_checker import lztd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                   m_tlast_i,
  input  logic                   m_tuser_i,
  output int unsigned            pending_o,
  output int unsigned            errors_o
);

  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH_DEF);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              bad;
  } dec_byte_t;

  // Predicted decoder state; the window is never read before it is written
  logic [BYTE_W-1:0]  hist_mem [HISTORY_DEPTH_DEF];
  logic [HIST_AW-1:0] wr_ptr;
  int unsigned        produced;
  int unsigned        err_cnt;
  dec_byte_t          expected_bytes_q [$];

  // Append one byte to the predicted window
  task automatic append_byte(input logic [BYTE_W-1:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (produced < HISTORY_DEPTH_DEF) produced++;
  endtask

  // Expand one token into the bytes it must produce
  task automatic decode_token(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] lit);
    int unsigned        run_len;
    int unsigned        k;
    logic               bad;
    logic [HIST_AW-1:0] idx;
    logic [BYTE_W-1:0]  b;
    run_len = (len > MAX_MATCH_DEF) ? MAX_MATCH_DEF : len;
    bad = (run_len != 0) && ((off == 0) || (off > produced));
    if (run_len != 0 && !bad) begin
      for (k = 0; k < run_len; k++) begin
        // offset of a full window wraps onto the write slot itself
        idx = wr_ptr - off[HIST_AW-1:0];
        b = hist_mem[idx];
        expected_bytes_q.push_back('{data: b, last: 1'b0, bad: 1'b0});
        append_byte(b);
      end
    end
    expected_bytes_q.push_back('{data: lit, last: 1'b1, bad: bad});
    append_byte(lit);
  endtask

  // Predict on each accepted request, then check each accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    dec_byte_t exp_b;
    if (!rst_ni) begin
      expected_bytes_q.delete();
      wr_ptr   = '0;
      produced = 0;
      err_cnt  = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        decode_token(s_tdata_i[OFF_W-1:0], s_tdata_i[OFF_W+LEN_W-1:OFF_W],
                     s_tdata_i[OFF_W+LEN_W+BYTE_W-1:OFF_W+LEN_W]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_bytes_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected byte %02h last %0b bad %0b", $realtime,
                     m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          exp_b = expected_bytes_q.pop_front();
          if (m_tdata_i !== exp_b.data || m_tlast_i !== exp_b.last ||
              m_tuser_i !== exp_b.bad) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: byte mismatch: expected %02h last %0b bad %0b, got %02h last %0b bad %0b",
                       $realtime, exp_b.data, exp_b.last, exp_b.bad,
                       m_tdata_i, m_tlast_i, m_tuser_i);
          end
        end
      end
      pending_o <= expected_bytes_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the LZ77 token decoder: clock, reset, token stimulus, verdict.
// Depends on lztd_pkg, lz77_token_decoder and lztd_checker.
`timescale 1ns / 100ps

module tb;
  import lztd_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;
  int unsigned            pending;
  int unsigned            errors;

  int unsigned src_idle_pct = 32;
  int unsigned dst_idle_pct = 85;
  int unsigned sent_bytes   = 0;  // window fill as seen by the stimulus

  always #2 clk_i = ~clk_i;

  lz77_token_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  lztd_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .m_tlast_i (m_axis_tlast),
    .m_tuser_i (m_axis_tuser),
    .pending_o (pending),
    .errors_o  (errors)
  );

  // Throttle the output side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
  end

  // Send one token request, idling at random first
  task automatic send_token(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] lit);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-OFF_W-LEN_W-BYTE_W){1'b0}}, lit, len, off};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // track the window fill so random offsets land inside it
    if (len != 0 && (off == 0 || off > sent_bytes)) sent_bytes += 1;
    else sent_bytes += len + 1;
    if (sent_bytes > HISTORY_DEPTH_DEF) sent_bytes = HISTORY_DEPTH_DEF;
  endtask

  // Hold the input until every predicted byte has come out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly well-formed back references, some literals and some noise
  task automatic random_tokens(input int unsigned count);
    int unsigned      n;
    int unsigned      r;
    int unsigned      span;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99, 0);
      len = ($urandom_range(4, 0) == 0) ? LEN_W'($urandom_range(63, 21))
                                        : LEN_W'($urandom_range(20, 1));
      if (r < 85 && sent_bytes != 0) begin
        span = (sent_bytes > HISTORY_DEPTH_DEF) ? HISTORY_DEPTH_DEF : sent_bytes;
        if (r < 70) begin
          off = OFF_W'($urandom_range((span > 48) ? 48 : span, 1));
        end else if ($urandom_range(3, 0) == 0) begin
          off = OFF_W'(span);
        end else begin
          off = OFF_W'($urandom_range(span, 1));
        end
      end else if (r < 92) begin
        off = OFF_W'($urandom_range(8191, 0));
        len = '0;
      end else begin
        off = OFF_W'($urandom_range(8191, 0));
        len = LEN_W'($urandom_range(63, 0));
      end
      send_token(off, len, BYTE_W'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    int unsigned wait_cnt;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: literals, bad offsets, overlap, window edge, full lengths
    send_token(13'd0, 6'd0, 8'h00);
    send_token(13'd2, 6'd1, 8'hFF);
    send_token(13'd0, 6'd5, 8'hA5);
    send_token(13'd8191, 6'd0, 8'h5A);
    send_token(13'd4, 6'd3, 8'hC3);
    send_token(13'd9, 6'd2, 8'h11);
    send_token(13'd1, 6'd63, 8'h3C);
    send_token(13'd3, 6'd40, 8'hE7);
    send_token(13'd8191, 6'd63, 8'h00);
    send_token(13'd4096, 6'd1, 8'h80);
    send_token(13'd100, 6'd20, 8'h7F);
    send_token(OFF_W'(sent_bytes), 6'd63, 8'h42);
    send_token(13'd7, 6'd0, 8'hFF);
    drain();

    random_tokens(140);
    drain();

    src_idle_pct = 85;
    dst_idle_pct = 32;
    random_tokens(140);
    drain();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_tokens(140);
    s_axis_tvalid <= 1'b0;

    // Wait for the last bytes, then let the pipeline settle
    wait_cnt = 0;
    do begin
      @(posedge clk_i);
      wait_cnt++;
    end while (pending != 0 && wait_cnt < 200000);
    repeat (200) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lztd_pkg.sv
hw/rtl/lztd_ram.sv
hw/rtl/lztd_ctrl.sv
hw/rtl/lztd_datapath.sv
hw/rtl/lz77_token_decoder.sv
verif/lztd_checker.sv
verif/tb.sv
